### src/qbf_pkg.sv
// qbf_pkg: shared types and constants of the quadratic bezier flattener
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package qbf_pkg;

  localparam int LVL_W     = 3;
  localparam int CFG_IDX_W = 3;

  // deepest subdivision level, a piece at this level is emitted as is
  localparam logic [LVL_W-1:0] MAX_DEPTH = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLATNESS = 3'd4;

  typedef logic signed [31:0] fix_t;

  // one curve piece: three points in Q16.16 and its subdivision level
  typedef struct packed {
    fix_t             bx;
    fix_t             by;
    fix_t             cx;
    fix_t             cy;
    fix_t             fx;
    fix_t             fy;
    logic [LVL_W-1:0] lvl;
  } piece_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

### src/quad_bezier_flattener.sv
// quad_bezier_flattener: top level, sequencer, config registers, output register
// depends on qbf_pkg, qbf_xform, qbf_subdiv, qbf_stack
//
//   channel  ports                                        direction
//   in       in_valid/in_ready, in_begin_x .. in_finish_y  curve request in
//   out      out_valid/out_ready, out_line_*, out_last_*   segment out
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data      register write in
//
// a curve is accepted, then transformed coordinate by coordinate on the one multiplier,
// then each piece passes the three evaluation states of the subdivision unit.
// in_ready is high only while idle.
// reset (synchronous, rst_n low) restores the config defaults and empties the stack.
// a flat piece waits in the last evaluation stage while the output register is full.
`timescale 1ns / 1ps

module quad_bezier_flattener import qbf_pkg::*; #(
  parameter int STACK_ENTRIES = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   in_begin_x,
  input  logic signed [15:0]   in_begin_y,
  input  logic signed [15:0]   in_control_x,
  input  logic signed [15:0]   in_control_y,
  input  logic signed [15:0]   in_finish_x,
  input  logic signed [15:0]   in_finish_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_line_x0,
  output logic signed [31:0]   out_line_y0,
  output logic signed [31:0]   out_line_x1,
  output logic signed [31:0]   out_line_y1,
  output logic                 out_last_segment,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int SP_W = $clog2(STACK_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_XF   = 3'd1;
  localparam logic [2:0] ST_EVA  = 3'd2;
  localparam logic [2:0] ST_EVB  = 3'd3;
  localparam logic [2:0] ST_EVC  = 3'd4;

  logic [2:0]  state_r;
  logic [2:0]  k_r;
  fix_t        scale_x_r, scale_y_r, offset_x_r, offset_y_r;
  logic [30:0] flatness_r;

  logic signed [15:0] coord_r [6];
  piece_t             cur_r;

  logic        out_valid_r;
  fix_t        out_x0_r, out_y0_r, out_x1_r, out_y1_r;
  logic        out_last_r;

  logic signed [15:0] xf_coord;
  fix_t               xf_scale, xf_offset, xf_result;
  logic               near;
  piece_t             lo_half, hi_half, top_data;
  logic [SP_W-1:0]    count;
  stk_ctl_t           stk_ctl;
  logic               piece_flat, out_free, emit;

  qbf_xform u_xform (
    .clk    (clk),
    .coord  (xf_coord),
    .scale  (xf_scale),
    .offset (xf_offset),
    .result (xf_result)
  );

  qbf_subdiv u_subdiv (
    .clk      (clk),
    .cur      (cur_r),
    .flatness (flatness_r),
    .near     (near),
    .lo_half  (lo_half),
    .hi_half  (hi_half)
  );

  qbf_stack #(.STACK_ENTRIES(STACK_ENTRIES)) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_data (lo_half),
    .top_data  (top_data),
    .count     (count)
  );

  // even coordinates are x, odd are y; the adder works on the previous one
  always_comb begin
    case (k_r)
      3'd0:    xf_coord = coord_r[0];
      3'd1:    xf_coord = coord_r[1];
      3'd2:    xf_coord = coord_r[2];
      3'd3:    xf_coord = coord_r[3];
      3'd4:    xf_coord = coord_r[4];
      3'd5:    xf_coord = coord_r[5];
      default: xf_coord = '0;
    endcase
  end
  assign xf_scale  = k_r[0] ? scale_y_r : scale_x_r;
  assign xf_offset = k_r[0] ? offset_x_r : offset_y_r;

  assign piece_flat = near || (cur_r.lvl >= MAX_DEPTH) ||
                      ((SP_W+1)'(count) + (SP_W+1)'(2) > (SP_W+1)'(STACK_ENTRIES));
  assign out_free   = !out_valid_r || out_ready;
  assign emit       = (state_r == ST_EVC) && piece_flat && out_free;

  assign stk_ctl.push = (state_r == ST_EVC) && !piece_flat;
  assign stk_ctl.pop  = emit && (count != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      scale_x_r   <= 32'sd65536;
      scale_y_r   <= 32'sd65536;
      offset_x_r  <= '0;
      offset_y_r  <= '0;
      flatness_r  <= 31'd32768;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCALE_X:  scale_x_r  <= cfg_data;
          CFG_SCALE_Y:  scale_y_r  <= cfg_data;
          CFG_OFFSET_X: offset_x_r <= cfg_data;
          CFG_OFFSET_Y: offset_y_r <= cfg_data;
          CFG_FLATNESS: flatness_r <= cfg_data[30:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            k_r     <= '0;
            state_r <= ST_XF;
          end
        end
        ST_XF: begin
          k_r <= k_r + 3'd1;
          if (k_r == 3'd6) begin
            state_r <= ST_EVA;
          end
        end
        ST_EVA: state_r <= ST_EVB;
        ST_EVB: state_r <= ST_EVC;
        ST_EVC: begin
          if (!piece_flat) begin
            state_r <= ST_EVA;
          end else if (out_free) begin
            state_r <= (count == '0) ? ST_IDLE : ST_EVA;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      coord_r[0] <= in_begin_x;
      coord_r[1] <= in_begin_y;
      coord_r[2] <= in_control_x;
      coord_r[3] <= in_control_y;
      coord_r[4] <= in_finish_x;
      coord_r[5] <= in_finish_y;
    end

    if (state_r == ST_XF) begin
      case (k_r)
        3'd1: cur_r.bx <= xf_result;
        3'd2: cur_r.by <= xf_result;
        3'd3: cur_r.cx <= xf_result;
        3'd4: cur_r.cy <= xf_result;
        3'd5: cur_r.fx <= xf_result;
        3'd6: begin
          cur_r.fy  <= xf_result;
          cur_r.lvl <= '0;
        end
        default: ;
      endcase
    end else if (state_r == ST_EVC) begin
      if (!piece_flat) begin
        // earlier half goes on the stack, later half is worked on next
        cur_r <= hi_half;
      end else if (stk_ctl.pop) begin
        cur_r <= top_data;
      end
    end

    if (emit) begin
      out_x0_r   <= cur_r.bx;
      out_y0_r   <= cur_r.by;
      out_x1_r   <= cur_r.fx;
      out_y1_r   <= cur_r.fy;
      out_last_r <= (count == '0);
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_line_x0      = out_x0_r;
  assign out_line_y0      = out_y0_r;
  assign out_line_x1      = out_x1_r;
  assign out_line_y1      = out_y1_r;
  assign out_last_segment = out_last_r;

endmodule

### src/qbf_xform.sv
// qbf_xform: shared multiply-add-saturate unit for the affine transform
// depends on qbf_pkg; product registered, offset add and clamp follow
`timescale 1ns / 1ps

module qbf_xform import qbf_pkg::*; (
  input  logic               clk,
  input  logic signed [15:0] coord,
  input  fix_t               scale,
  input  fix_t               offset,
  output fix_t               result
);

  logic signed [47:0] prod_r;
  logic signed [47:0] prod_nxt;
  logic signed [48:0] sum;

  assign prod_nxt = 48'(coord) * 48'(scale);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign sum = {prod_r[47], prod_r} + {{17{offset[31]}}, offset};

  // clamp to the signed 32 bit range
  always_comb begin
    if (!sum[48] && (sum[47:31] != 17'h00000)) begin
      result = 32'sh7fffffff;
    end else if (sum[48] && (sum[47:31] != 17'h1ffff)) begin
      result = 32'sh80000000;
    end else begin
      result = sum[31:0];
    end
  end

endmodule

### src/qbf_subdiv.sv
// qbf_subdiv: three stage evaluation of one curve piece (flatness and halves)
// depends on qbf_pkg; the input piece must stay stable for three cycles
`timescale 1ns / 1ps

module qbf_subdiv import qbf_pkg::*; (
  input  logic        clk,
  input  piece_t      cur,
  input  logic [30:0] flatness,
  output logic        near,
  output piece_t      lo_half,
  output piece_t      hi_half
);

  // floor((a + b) / 2), always fits 32 bits
  function automatic fix_t half_floor(input fix_t a, input fix_t b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return s[32:1];
  endfunction

  fix_t mx_r, my_r, c0x_r, c0y_r, c1x_r, c1y_r;
  fix_t vx_r, vy_r;
  logic [32:0] adx_r, ady_r;

  logic signed [32:0] dx, dy, ndx, ndy;
  logic [33:0] man_dist;

  assign dx  = {cur.cx[31], cur.cx} - {mx_r[31], mx_r};
  assign dy  = {cur.cy[31], cur.cy} - {my_r[31], my_r};
  assign ndx = {mx_r[31], mx_r} - {cur.cx[31], cur.cx};
  assign ndy = {my_r[31], my_r} - {cur.cy[31], cur.cy};

  always_ff @(posedge clk) begin
    // stage a: chord midpoint and control midpoints
    mx_r  <= half_floor(cur.bx, cur.fx);
    my_r  <= half_floor(cur.by, cur.fy);
    c0x_r <= half_floor(cur.bx, cur.cx);
    c0y_r <= half_floor(cur.by, cur.cy);
    c1x_r <= half_floor(cur.cx, cur.fx);
    c1y_r <= half_floor(cur.cy, cur.fy);
    // stage b: distance terms and split point
    adx_r <= dx[32] ? ndx : dx;
    ady_r <= dy[32] ? ndy : dy;
    vx_r  <= half_floor(c0x_r, c1x_r);
    vy_r  <= half_floor(c0y_r, c1y_r);
  end

  // stage c: manhattan distance against tolerance
  assign man_dist = {1'b0, adx_r} + {1'b0, ady_r};
  assign near     = (man_dist <= {3'b000, flatness});

  assign lo_half = '{bx: cur.bx, by: cur.by, cx: c0x_r, cy: c0y_r,
                     fx: vx_r, fy: vy_r, lvl: cur.lvl + 3'd1};
  assign hi_half = '{bx: vx_r, by: vy_r, cx: c1x_r, cy: c1y_r,
                     fx: cur.fx, fy: cur.fy, lvl: cur.lvl + 3'd1};

endmodule

### src/qbf_stack.sv
// qbf_stack: register stack of pending curve pieces, one push or pop a cycle
// depends on qbf_pkg
`timescale 1ns / 1ps

module qbf_stack import qbf_pkg::*; #(
  parameter int STACK_ENTRIES = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stk_ctl_t                           ctl,
  input  piece_t                             push_data,
  output piece_t                             top_data,
  output logic [$clog2(STACK_ENTRIES+1)-1:0] count
);

  localparam int SP_W  = $clog2(STACK_ENTRIES + 1);
  localparam int IDX_W = $clog2(STACK_ENTRIES);

  piece_t           entries_r [STACK_ENTRIES];
  logic [SP_W-1:0]  count_r;
  logic [SP_W-1:0]  top_pos;
  logic [IDX_W-1:0] top_idx;

  assign top_pos = count_r - SP_W'(1);
  assign top_idx = top_pos[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.push) begin
      count_r <= count_r + SP_W'(1);
    end else if (ctl.pop) begin
      count_r <= top_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries_r[count_r[IDX_W-1:0]] <= push_data;
    end
  end

  assign top_data = entries_r[top_idx];
  assign count    = count_r;

endmodule

### sim/tb_quad_bezier_flattener.sv
// tb_quad_bezier_flattener: self-checking bench for the quadratic bezier flattener
// directed table then random curves under changing transforms, checked by a segment predictor
// depends on qbf_pkg and quad_bezier_flattener
`timescale 1ns / 1ps

module tb_quad_bezier_flattener;
  import qbf_pkg::*;

  localparam int STK_DEPTH   = 7;
  localparam int MAX_SEGS    = 64;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 30;
  localparam int SETTLE      = 400;
  localparam int STALL_LIMIT = 20000;

  localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
  localparam fix_t FIX_MIN = 32'sh8000_0000;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = CFG_FLATNESS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = '1;

  typedef struct packed {
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
  } curve_t;

  typedef struct packed {
    fix_t x0;
    fix_t y0;
    fix_t x1;
    fix_t y1;
    logic last;
  } seg_t;

  typedef enum logic [1:0] {ROW_CURVE, ROW_TYPED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    curve_t               crv;
    seg_t                 want;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic signed [15:0]   in_begin_x, in_begin_y, in_control_x, in_control_y;
  logic signed [15:0]   in_finish_x, in_finish_y;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   out_line_x0, out_line_y0, out_line_x1, out_line_y1;
  logic                 out_last_segment;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  // transform and tolerance as the block should hold them
  fix_t   sc_x, sc_y, of_x, of_y;
  longint flat_tol;

  seg_t seg_q[$];
  row_t dir_rows[$];

  bit steady = 1'b0;
  bit in_up = 1'b0;
  bit cfg_up = 1'b0;
  int n_err = 0;
  int n_curves = 0;
  int n_segs = 0;
  int n_writes = 0;
  int quiet = 0;

  always #2 clk = ~clk;

  quad_bezier_flattener #(.STACK_ENTRIES(STK_DEPTH)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_begin_x       (in_begin_x),
    .in_begin_y       (in_begin_y),
    .in_control_x     (in_control_x),
    .in_control_y     (in_control_y),
    .in_finish_x      (in_finish_x),
    .in_finish_y      (in_finish_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_line_x0      (out_line_x0),
    .out_line_y0      (out_line_y0),
    .out_line_x1      (out_line_x1),
    .out_line_y1      (out_line_y1),
    .out_last_segment (out_last_segment),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_err++;
  endtask

  function automatic fix_t map_coord(input logic signed [15:0] v, input fix_t scale,
                                     input fix_t offset);
    longint acc;
    acc = longint'(v) * longint'(scale) + longint'(offset);
    if (acc > longint'(FIX_MAX)) return FIX_MAX;
    if (acc < longint'(FIX_MIN)) return FIX_MIN;
    return fix_t'(acc);
  endfunction

  // floor of the mean, always fits back in 32 bits
  function automatic fix_t halve_sum(input fix_t a, input fix_t b);
    longint s;
    s = longint'(a) + longint'(b);
    return fix_t'(s >>> 1);
  endfunction

  function automatic longint abs_diff(input fix_t a, input fix_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // depth-first de casteljau split, later half popped first
  task automatic predict_segments(input curve_t c);
    piece_t stk [STK_DEPTH];
    piece_t pc, lo, hi;
    seg_t   s;
    fix_t   mx, my, c0x, c0y, c1x, c1y, vx, vy;
    longint man_dist;
    bit     flat;
    int     sp, produced;
    pc.bx  = map_coord(c.bx, sc_x, of_x);
    pc.by  = map_coord(c.by, sc_y, of_y);
    pc.cx  = map_coord(c.cx, sc_x, of_x);
    pc.cy  = map_coord(c.cy, sc_y, of_y);
    pc.fx  = map_coord(c.fx, sc_x, of_x);
    pc.fy  = map_coord(c.fy, sc_y, of_y);
    pc.lvl = '0;
    stk[0] = pc;
    sp = 1;
    produced = 0;
    while (sp > 0) begin
      sp--;
      pc = stk[sp];
      mx = halve_sum(pc.bx, pc.fx);
      my = halve_sum(pc.by, pc.fy);
      man_dist = abs_diff(pc.cx, mx) + abs_diff(pc.cy, my);
      flat = (man_dist <= flat_tol) || (pc.lvl >= MAX_DEPTH) || (sp + 2 > STK_DEPTH);
      if (flat) begin
        if (produced < MAX_SEGS) begin
          s.x0 = pc.bx;
          s.y0 = pc.by;
          s.x1 = pc.fx;
          s.y1 = pc.fy;
          s.last = (sp == 0);
          seg_q.push_back(s);
          produced++;
        end
      end else begin
        c0x = halve_sum(pc.bx, pc.cx);
        c0y = halve_sum(pc.by, pc.cy);
        c1x = halve_sum(pc.cx, pc.fx);
        c1y = halve_sum(pc.cy, pc.fy);
        vx  = halve_sum(c0x, c1x);
        vy  = halve_sum(c0y, c1y);
        lo = pc;
        lo.cx = c0x;
        lo.cy = c0y;
        lo.fx = vx;
        lo.fy = vy;
        lo.lvl = pc.lvl + 1'b1;
        hi = pc;
        hi.bx = vx;
        hi.by = vy;
        hi.cx = c1x;
        hi.cy = c1y;
        hi.lvl = pc.lvl + 1'b1;
        stk[sp] = lo;
        stk[sp + 1] = hi;
        sp += 2;
      end
    end
  endtask

  function automatic int gap_len();
    int g;
    g = 0;
    if (!steady) begin
      while ($urandom_range(99) < 26) g++;
    end
    return g;
  endfunction

  function automatic logic [15:0] near(input logic [15:0] base, input int spread);
    int v;
    v = int'($signed(base)) + int'($urandom_range(0, 2 * spread)) - spread;
    return v[15:0];
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(9))
      0: return 32'h0001_0000;
      1: return 32'hFFFF_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_offset();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom;
      default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [31:0] pick_flat();
    case ($urandom_range(6))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      3: return 32'h0000_8000;
      default: return $urandom_range(0, 32'h0004_0000);
    endcase
  endfunction

  function automatic void add_curve(input int bx, by, cx, cy, fx, fy);
    row_t r;
    r.kind = ROW_CURVE;
    r.idx = '0;
    r.data = '0;
    r.crv = {bx[15:0], by[15:0], cx[15:0], cy[15:0], fx[15:0], fy[15:0]};
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  // single flat segment, known without the predictor
  function automatic void add_typed(input int bx, by, cx, cy, fx, fy,
                                    input logic [31:0] x0, y0, x1, y1);
    row_t r;
    r.kind = ROW_TYPED;
    r.idx = '0;
    r.data = '0;
    r.crv = {bx[15:0], by[15:0], cx[15:0], cy[15:0], fx[15:0], fy[15:0]};
    r.want = {x0, y0, x1, y1, 1'b1};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.data = data;
    r.crv = '0;
    r.want = '0;
    dir_rows.push_back(r);
  endfunction

  task automatic send_curve(input curve_t c, input int gap, input bit typed,
                            input seg_t want);
    bit took;
    if (cfg_up) begin
      cfg_valid <= 1'b0;
      cfg_up = 1'b0;
    end
    if (gap > 0) begin
      if (in_up) begin
        in_valid <= 1'b0;
        in_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_up = 1'b1;
    in_begin_x   <= c.bx;
    in_begin_y   <= c.by;
    in_control_x <= c.cx;
    in_control_y <= c.cy;
    in_finish_x  <= c.fx;
    in_finish_y  <= c.fy;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    n_curves++;
    if (typed) seg_q.push_back(want);
    else predict_segments(c);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_up = 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    n_writes++;
    case (idx)
      CFG_SCALE_X:  sc_x = fix_t'(data);
      CFG_SCALE_Y:  sc_y = fix_t'(data);
      CFG_OFFSET_X: of_x = fix_t'(data);
      CFG_OFFSET_Y: of_y = fix_t'(data);
      CFG_FLATNESS: flat_tol = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  // hold off new curves until every segment owed has come out
  task automatic drain_results();
    if (in_up) begin
      in_valid <= 1'b0;
      in_up = 1'b0;
    end
    do @(posedge clk); while (seg_q.size() != 0);
  endtask

  always @(posedge clk) begin
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin : seg_check
    seg_t want;
    if (rst_n && out_valid && out_ready) begin
      if (seg_q.size() == 0) begin
        report($sformatf("segment (%h,%h)-(%h,%h) with nothing owed",
                         out_line_x0, out_line_y0, out_line_x1, out_line_y1));
      end else begin
        want = seg_q.pop_front();
        n_segs++;
        if (out_line_x0 !== want.x0)
          report($sformatf("line_x0 %h, want %h", out_line_x0, want.x0));
        if (out_line_y0 !== want.y0)
          report($sformatf("line_y0 %h, want %h", out_line_y0, want.y0));
        if (out_line_x1 !== want.x1)
          report($sformatf("line_x1 %h, want %h", out_line_x1, want.x1));
        if (out_line_y1 !== want.y1)
          report($sformatf("line_y1 %h, want %h", out_line_y1, want.y1));
        if (out_last_segment !== want.last)
          report($sformatf("last_segment %b, want %b", out_last_segment, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stim
    curve_t    c;
    row_kind_t prev_kind;
    logic [15:0] base_x, base_y;
    int     spread, r, mid;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_begin_x   = '0;
    in_begin_y   = '0;
    in_control_x = '0;
    in_control_y = '0;
    in_finish_x  = '0;
    in_finish_y  = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    sc_x = 32'sh0001_0000;
    sc_y = 32'sh0001_0000;
    of_x = '0;
    of_y = '0;
    flat_tol = 64'sd32768;

    // reset transform: identity, tolerance one half
    add_typed(0, 0, 0, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0);
    add_typed(32767, -32768, 32767, -32768, 32767, -32768,
              32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_0000, 32'h8000_0000);
    add_typed(-32768, 32767, -32768, 32767, -32768, 32767,
              32'h8000_0000, 32'h7FFF_0000, 32'h8000_0000, 32'h7FFF_0000);
    add_typed(0, 0, 1, 1, 2, 2, 32'h0, 32'h0, 32'h0002_0000, 32'h0002_0000);
    // control exactly at the tolerance from the chord midpoint
    add_typed(0, 0, 0, 0, 1, 0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    add_curve(0, 0, 1, 1, 1, 0);
    add_curve(0, 0, 1, 1, 2, 0);
    add_curve(-1, -1, -3, 5, -2, -7);
    // full depth, stack runs out of room
    add_curve(-32768, -32768, 32767, -32768, 32767, 32767);
    add_curve(32767, 32767, -32768, 0, 32767, -32768);
    // saturating transform
    add_write(CFG_SCALE_X, 32'h7FFF_FFFF);
    add_write(CFG_SCALE_Y, 32'h8000_0000);
    add_typed(32767, 32767, 32767, 32767, 32767, 32767,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_typed(-32768, -32768, -32768, -32768, -32768, -32768,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_curve(1, 1, -1, 2, 0, -1);
    // zero scale collapses every curve onto the offset
    add_write(CFG_SCALE_X, 32'h0);
    add_write(CFG_SCALE_Y, 32'h0);
    add_write(CFG_OFFSET_X, 32'h7FFF_FFFF);
    add_write(CFG_OFFSET_Y, 32'h8000_0000);
    add_typed(5, -9, 1234, -32768, 32767, 0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_write(CFG_NONE_LO, 32'h0);
    add_write(CFG_NONE_HI, 32'hFFFF_FFFF);
    add_typed(-32768, 32767, 0, 1, -5, 77,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    // mirrored y, half-unit offsets, zero tolerance
    add_write(CFG_SCALE_X, 32'h0001_0000);
    add_write(CFG_SCALE_Y, 32'hFFFF_0000);
    add_write(CFG_OFFSET_X, 32'hFFFF_8000);
    add_write(CFG_OFFSET_Y, 32'h0000_8000);
    add_write(CFG_FLATNESS, 32'h0);
    add_curve(0, 0, 0, 0, 1, 0);
    add_typed(0, 0, 2, 2, 4, 4, 32'hFFFF_8000, 32'h0000_8000, 32'h0003_8000, 32'hFFFC_8000);
    add_curve(100, -100, -200, 300, 50, 60);
    // top bit of the tolerance write is dropped
    add_write(CFG_FLATNESS, 32'hFFFF_FFFF);
    add_typed(0, 0, 10, 10, 0, 20, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_8000, 32'hFFEC_8000);
    add_curve(-32768, -32768, 32767, -32768, 32767, 32767);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    prev_kind = ROW_CURVE;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        if (prev_kind != ROW_WRITE) drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_curve(dir_rows[i].crv, gap_len(), dir_rows[i].kind == ROW_TYPED,
                   dir_rows[i].want);
      end
      prev_kind = dir_rows[i].kind;
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      write_reg(CFG_SCALE_X, pick_scale());
      write_reg(CFG_SCALE_Y, pick_scale());
      write_reg(CFG_OFFSET_X, pick_offset());
      write_reg(CFG_OFFSET_Y, pick_offset());
      write_reg(CFG_FLATNESS, pick_flat());
      if ($urandom_range(3) == 0)
        write_reg(CFG_NONE_LO + CFG_IDX_W'($urandom_range(int'(CFG_NONE_HI - CFG_NONE_LO))),
                  $urandom);
      // one phase runs with neither side holding back
      steady <= (ph == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        if (r < 12) begin
          c = curve_t'({$urandom, $urandom, $urandom});
        end else begin
          spread = (r < 70) ? 8 : 600;
          base_x = 16'($urandom);
          base_y = 16'($urandom);
          c.bx = near(base_x, spread);
          c.by = near(base_y, spread);
          c.cx = near(base_x, spread);
          c.cy = near(base_y, spread);
          c.fx = near(base_x, spread);
          c.fy = near(base_y, spread);
          if ($urandom_range(9) == 0) begin
            // control on the chord
            mid = (int'(c.bx) + int'(c.fx)) >>> 1;
            c.cx = mid[15:0];
            mid = (int'(c.by) + int'(c.fy)) >>> 1;
            c.cy = mid[15:0];
          end
        end
        send_curve(c, gap_len(), 1'b0, '0);
      end
    end

    steady <= 1'b0;
    drain_results();
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d curves (%0d table rows) over %0d transform phases", n_curves,
             dir_rows.size(), N_PHASES);
    $display("checked %0d segments, %0d register writes, %0d mismatches", n_segs, n_writes,
             n_err);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
